[rtl/rmct_pkg.sv]
// Shared types and constants for the range minimum count tree.
package rmct_pkg;

  localparam int NUM_LEAVES = 1024;
  localparam int LEAF_W     = $clog2(NUM_LEAVES);
  localparam int NODE_W     = LEAF_W + 1;
  localparam int NODE_DEPTH = 2 * NUM_LEAVES;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 11;
  localparam int RIGHT_W    = 11;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = SIZE_W'(NUM_LEAVES);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [CNT_W-1:0]   CNT_ZERO    = '0;
  localparam logic [CNT_W-1:0]   CNT_ONE     = CNT_W'(1);
  localparam logic               CMD_SET     = 1'b0;
  localparam logic               CMD_QUERY   = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [LEAF_W-1:0]        position;
    logic signed [VAL_W-1:0]  value;
    logic [LEAF_W-1:0]        left;
    logic [RIGHT_W-1:0]       right_end;
  } rmct_in_t;

  // Result item; the same shape is kept in every tree node.
  typedef struct packed {
    logic signed [VAL_W-1:0]  minimum;
    logic [CNT_W-1:0]         min_count;
  } rmct_out_t;

  localparam int NODE_BITS = $bits(rmct_out_t);

  typedef struct packed {
    logic load;
    logic set_leaf;
    logic set_up;
    logic q_lo;
    logic q_hi;
    logic out_load;
  } rmct_cmd_t;

  typedef struct packed {
    logic is_query;
    logic set_ok;
    logic lo_lt_hi;
    logic k_root;
    logic out_free;
  } rmct_sts_t;

endpackage

[rtl/rmct_ram.sv]
// Generic single write port, single read port RAM with registered read.
module rmct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rmct_ctrl.sv]
// Sequencer for set and query walks over the tree.
module rmct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmct_pkg::rmct_sts_t sts_i,
  output rmct_pkg::rmct_cmd_t cmd_o
);
  import rmct_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_LEAF,
    ST_SET_UP,
    ST_Q_LO,
    ST_Q_HI,
    ST_Q_DONE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (sts_i.is_query) begin
              state_q <= ST_Q_LO;
            end else if (sts_i.set_ok) begin
              state_q <= ST_SET_LEAF;
            end
          end
        end
        ST_SET_LEAF: state_q <= ST_SET_UP;
        ST_SET_UP: begin
          if (sts_i.k_root) begin
            state_q <= ST_IDLE;
          end
        end
        ST_Q_LO: begin
          state_q <= sts_i.lo_lt_hi ? ST_Q_HI : ST_Q_DONE;
        end
        ST_Q_HI: state_q <= ST_Q_LO;
        ST_Q_DONE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.set_leaf = (state_q == ST_SET_LEAF);
    cmd_o.set_up   = (state_q == ST_SET_UP);
    cmd_o.q_lo     = (state_q == ST_Q_LO);
    cmd_o.q_hi     = (state_q == ST_Q_HI);
    cmd_o.out_load = (state_q == ST_Q_DONE) && sts_i.out_free;
  end

endmodule

[rtl/rmct_dp.sv]
// Datapath: node memory, walk indices, merge unit and output register.
module rmct_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [rmct_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  rmct_pkg::rmct_in_t  in_data_i,
  output rmct_pkg::rmct_out_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rmct_pkg::rmct_cmd_t cmd_i,
  output rmct_pkg::rmct_sts_t sts_o
);
  import rmct_pkg::*;

  function automatic rmct_out_t merge_node(rmct_out_t a, rmct_out_t b);
    rmct_out_t r;
    r = a;
    if ($signed(b.minimum) < $signed(a.minimum)) begin
      r = b;
    end else if (b.minimum == a.minimum) begin
      r.min_count = a.min_count + b.min_count;
    end
    return r;
  endfunction

  logic [SIZE_W-1:0]  size_q;
  logic [SIZE_W-1:0]  eff_size;
  logic [SIZE_W-1:0]  clamp_end;
  logic [NODE_W-1:0]  k_q;
  logic [NODE_W-1:0]  k_up;
  logic [NODE_W:0]    lo_q, hi_q;
  logic [NODE_W:0]    hi_dec;
  rmct_out_t          carry_q, acc_q, out_q;
  logic               out_valid_q;
  logic               pend_q;
  logic               rd_lo, rd_hi;

  logic               ram_we;
  logic [NODE_W-1:0]  ram_waddr, ram_raddr;
  rmct_out_t          ram_wdata, ram_rdata, set_merged;
  logic [NODE_BITS-1:0] ram_rbits;

  assign eff_size  = (size_q > SIZE_LIMIT) ? SIZE_LIMIT : size_q;
  assign clamp_end = (SIZE_W'(in_data_i.right_end) > eff_size) ? eff_size
                                                                : SIZE_W'(in_data_i.right_end);
  assign k_up      = k_q >> 1;
  assign hi_dec    = hi_q - (NODE_W+1)'(1);
  assign ram_rdata = rmct_out_t'(ram_rbits);
  assign set_merged = merge_node(carry_q, ram_rdata);

  assign rd_lo = cmd_i.q_lo && (lo_q < hi_q) && lo_q[0];
  assign rd_hi = cmd_i.q_hi && hi_q[0];

  assign sts_o.is_query = (in_data_i.cmd == CMD_QUERY);
  assign sts_o.set_ok   = (SIZE_W'(in_data_i.position) < eff_size);
  assign sts_o.lo_lt_hi = (lo_q < hi_q);
  assign sts_o.k_root   = (k_up == NODE_W'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Write the leaf first, then one ancestor per cycle; the sibling read
  // for the next level overlaps the write of the current one.
  always_comb begin
    ram_we    = cmd_i.set_leaf || cmd_i.set_up;
    ram_waddr = cmd_i.set_leaf ? k_q : k_up;
    ram_wdata = cmd_i.set_leaf ? carry_q : set_merged;
    ram_raddr = '0;
    if (cmd_i.set_leaf) begin
      ram_raddr = k_q ^ NODE_W'(1);
    end else if (cmd_i.set_up) begin
      ram_raddr = k_up ^ NODE_W'(1);
    end else if (cmd_i.q_lo) begin
      ram_raddr = lo_q[NODE_W-1:0];
    end else if (cmd_i.q_hi) begin
      ram_raddr = hi_dec[NODE_W-1:0];
    end
  end

  rmct_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      pend_q <= rd_lo || rd_hi;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q               <= NODE_W'(NUM_LEAVES) + NODE_W'(in_data_i.position);
      carry_q.minimum   <= in_data_i.value;
      carry_q.min_count <= CNT_ONE;
      acc_q.minimum     <= VAL_MAX;
      acc_q.min_count   <= CNT_ZERO;
      lo_q              <= (NODE_W+1)'(NUM_LEAVES) + (NODE_W+1)'(in_data_i.left);
      hi_q              <= (NODE_W+1)'(NUM_LEAVES) + (NODE_W+1)'(clamp_end);
    end else begin
      if (cmd_i.set_up) begin
        k_q     <= k_up;
        carry_q <= set_merged;
      end
      if (pend_q) begin
        acc_q <= merge_node(acc_q, ram_rdata);
      end
      if (rd_lo) begin
        lo_q <= lo_q + (NODE_W+1)'(1);
      end
      if (cmd_i.q_hi) begin
        lo_q <= lo_q >> 1;
        hi_q <= hi_q >> 1;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= acc_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

[rtl/range_minimum_count_tree_core.sv]
// Top level of the range minimum count tree: segment tree with min and count.
//
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid_i/in_ready_o  in_data_i  (rmct_in_t)
//  out       output     out_valid_o/out_ready_i out_data_o (rmct_out_t)
//  cfg       input      cfg_we_i (no wait)     cfg_wdata_i (size in use)
//
//  One item at a time. A set is accepted, writes the leaf, then writes each
//  ancestor in turn up to the root. A set beyond the size in use is accepted
//  and dropped. A query walks up to log2(NUM_LEAVES) + 1 levels, reading the
//  left edge and then the right edge of each level, since the node memory has
//  a single read port. After the accept it closes with a range check and then
//  loads the result, waiting while the output register is still full.
//  Reset clears control and sets the size in use to 1024; node contents are
//  not cleared, every position in use must be set before it is queried.
//  A result waits in an output register, so a stalled output blocks the core
//  only when the next query is ready to hand over its result.
module range_minimum_count_tree_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [rmct_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rmct_pkg::rmct_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmct_pkg::rmct_out_t out_data_o
);
  import rmct_pkg::*;

  rmct_cmd_t cmd;
  rmct_sts_t sts;

  // Sequence the walks: leaf then ancestors for a set, edge pairs per
  // level for a query.
  rmct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the node memory, the walk indices and the result register.
  rmct_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the range minimum count tree: random sets and range queries.
`timescale 1ns / 1ps

module testbench;
  import rmct_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 40;    // margin after the queues drain so a trailing walk can finish
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off to back the tree up
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake before giving up

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  rmct_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  rmct_out_t           out_data_o;

  range_minimum_count_tree_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the tree: leaf i at node NUM_LEAVES + i, node k merges 2k and 2k+1.
  rmct_out_t         tree_nodes [NODE_DEPTH];
  logic [SIZE_W-1:0] size_copy = SIZE_RESET;

  rmct_in_t  items_to_send [$];   // items waiting for the driver
  rmct_out_t range_minima  [$];   // minimum/count answers still owed by the block

  int errors       = 0;
  int results_seen = 0;

  // Append one item to the driver's queue.
  function automatic void queue_item(input rmct_in_t it);
    items_to_send = {items_to_send, it};
  endfunction

  // Positions covered right now: the register value, capped at the leaf count.
  function automatic int unsigned live_size();
    live_size = (size_copy < SIZE_LIMIT) ? size_copy : NUM_LEAVES;
  endfunction

  // Fold one node into a running minimum: a smaller value replaces, a tie adds counts.
  function automatic void fold_min(inout rmct_out_t acc, input rmct_out_t nd);
    if (nd.minimum < acc.minimum) begin
      acc = nd;
    end else if (nd.minimum == acc.minimum) begin
      acc.min_count = acc.min_count + nd.min_count;
    end
  endfunction

  // Update the shadow tree for one accepted item; queue the answer of a query.
  function automatic void apply_to_tree(input rmct_in_t it);
    int unsigned lim, k, lo, hi;
    rmct_out_t   acc;
    lim = live_size();
    if (it.cmd == CMD_SET) begin
      // Drop a write beyond the covered positions.
      if (it.position < lim) begin
        k = NUM_LEAVES + it.position;
        tree_nodes[k] = '{minimum: it.value, min_count: CNT_ONE};
        // Re-merge every ancestor up to the root.
        while (k > 1) begin
          k   = k >> 1;
          acc = tree_nodes[2 * k];
          fold_min(acc, tree_nodes[2 * k + 1]);
          tree_nodes[k] = acc;
        end
      end
    end else begin
      acc = '{minimum: VAL_MAX, min_count: CNT_ZERO};
      lo  = it.left;
      hi  = it.right_end;
      // Clamp the end to the covered size; an empty range keeps the identity answer.
      if (hi > lim) hi = lim;
      if (lo < hi) begin
        lo += NUM_LEAVES;
        hi += NUM_LEAVES;
        // Walk both edges up, taking whole nodes that stick out of the parent span.
        while (lo < hi) begin
          if (lo[0]) begin
            fold_min(acc, tree_nodes[lo]);
            lo++;
          end
          if (hi[0]) begin
            hi--;
            fold_min(acc, tree_nodes[hi]);
          end
          lo = lo >> 1;
          hi = hi >> 1;
        end
      end
      range_minima = {range_minima, acc};
    end
  endfunction

  // Values: mostly a narrow band so ties (counts above one) are common,
  // plus full-range random words and the signed extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: pick_value = $urandom_range(0, 8) - 4;
      2:    pick_value = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       pick_value = VAL_MAX;
          1:       pick_value = VAL_MIN;
          2:       pick_value = '1;
          default: pick_value = '0;
        endcase
      end
    endcase
  endfunction

  // Unused fields carry random bits so every input bit toggles.
  function automatic rmct_in_t make_set(input int unsigned pos, input logic signed [VAL_W-1:0] v);
    rmct_in_t it;
    it          = {$urandom, $urandom};
    it.cmd      = CMD_SET;
    it.position = LEAF_W'(pos);
    it.value    = v;
    make_set    = it;
  endfunction

  function automatic rmct_in_t make_query(input int unsigned l, input int unsigned r);
    rmct_in_t it;
    it           = {$urandom, $urandom};
    it.cmd       = CMD_QUERY;
    it.left      = LEAF_W'(l);
    it.right_end = RIGHT_W'(r);
    make_query   = it;
  endfunction

  // Mostly well-formed traffic inside the covered size, some writes beyond it,
  // some ends past the size (clamped) and some arbitrary ranges, empty ones included.
  task automatic random_phase(input int count);
    int unsigned lim, l, r;
    repeat (count) begin
      lim = live_size();
      if ($urandom_range(0, 99) < 45) begin
        if (lim > 0 && $urandom_range(0, 9) != 0) l = $urandom_range(0, lim - 1);
        else l = $urandom_range(0, NUM_LEAVES - 1);
        queue_item(make_set(l, pick_value()));
      end else if (lim > 0 && $urandom_range(0, 7) != 0) begin
        l = $urandom_range(0, lim - 1);
        if ($urandom_range(0, 5) == 0) r = $urandom_range(lim, NUM_LEAVES);
        else r = $urandom_range(l + 1, lim);
        queue_item(make_query(l, r));
      end else begin
        queue_item(make_query($urandom_range(0, NUM_LEAVES - 1),
                              $urandom_range(0, NUM_LEAVES)));
      end
    end
  endtask

  // Wait until every item is taken and answered, then let a trailing set finish.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (items_to_send.size() != 0 || in_valid_i || range_minima.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the size register; only called while the block is idle.
  task automatic write_size(input logic [SIZE_W-1:0] sz);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    size_copy = sz;
    @(negedge clk_i);
  endtask

  // Stimulus: fill the item queue phase by phase; config changes only between phases.
  initial begin
    logic signed [VAL_W-1:0] fill_value;
    logic [SIZE_W-1:0]       sz;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Build the whole tree at the reset size with one value, so a full query counts 1024.
    fill_value = pick_value();
    for (int p = 0; p < NUM_LEAVES; p++) queue_item(make_set(p, fill_value));
    queue_item(make_query(0, NUM_LEAVES));
    queue_item(make_query(NUM_LEAVES - 1, NUM_LEAVES));
    queue_item(make_query(5, 5));
    queue_item(make_query(NUM_LEAVES - 1, 0));
    queue_item(make_set(0, VAL_MAX));
    queue_item(make_set(512, VAL_MIN));
    queue_item(make_set(NUM_LEAVES - 1, VAL_MIN));
    queue_item(make_query(0, NUM_LEAVES));
    queue_item(make_query(0, 1));
    queue_item(make_query(0, 512));
    queue_item(make_set(NUM_LEAVES - 1, '1));
    queue_item(make_query(513, NUM_LEAVES));
    random_phase(60);
    wait_idle();

    // One position: writes past it drop, query ends clamp to it.
    write_size(1);
    queue_item(make_set(0, '1));
    queue_item(make_set(1, '0));
    queue_item(make_set(NUM_LEAVES - 1, 5));
    queue_item(make_query(0, NUM_LEAVES));
    queue_item(make_query(0, 1));
    queue_item(make_query(1, NUM_LEAVES));
    queue_item(make_query(0, 0));
    random_phase(30);
    wait_idle();

    // Size zero: every write drops, every query is empty.
    write_size(0);
    queue_item(make_set(0, 3));
    queue_item(make_query(0, NUM_LEAVES));
    queue_item(make_query(0, 1));
    random_phase(15);
    wait_idle();

    // Register above the leaf count: the size caps at NUM_LEAVES.
    write_size('1);
    queue_item(make_query(0, NUM_LEAVES));
    random_phase(60);
    wait_idle();

    // Mostly small sizes, one nearly full, one anywhere in the register range.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) sz = NUM_LEAVES - 1;
      else if (ph == 6) sz = $urandom_range(0, 2047);
      else sz = $urandom_range(2, 64);
      write_size(sz);
      random_phase(40);
      wait_idle();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: offer queued items in bursts of random length with random gaps between.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) apply_to_tree(in_data_i);
      // Hold the current item until it is taken; only then advance.
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= items_to_send.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // New burst; a quarter of bursts follow on with no gap at all.
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each answer against the oldest owed one; drive the receiver's
  // stall pattern, with long hold-offs after the 20th and 200th answers.
  rmct_out_t want;
  logic      rx_level = 1'b1;
  int        rx_left  = 0;
  int        hold_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (range_minima.size() == 0) begin
          $display("%0t: answer with nothing owed, actual minimum %0d count %0d",
                   $time, out_data_o.minimum, out_data_o.min_count);
          errors++;
        end else begin
          want = range_minima.pop_front();
          if (out_data_o.minimum !== want.minimum) begin
            $display("%0t: minimum mismatch, expected %0d actual %0d",
                     $time, want.minimum, out_data_o.minimum);
            errors++;
          end
          if (out_data_o.min_count !== want.min_count) begin
            $display("%0t: min_count mismatch, expected %0d actual %0d",
                     $time, want.min_count, out_data_o.min_count);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == 20 || results_seen == 200) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // Hold off while the sender keeps offering, so the block backs up.
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        // Alternate ready and stall stretches: short stalls, longer ready runs.
        if (rx_left == 0) begin
          rx_level = ~rx_level;
          rx_left  = rx_level ? $urandom_range(1, 50) : $urandom_range(1, 12);
        end else begin
          rx_left--;
        end
        out_ready_i <= rx_level;
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
